@@ sv/core_local_interruptor_defines.svh @@
// ----------------------------------------------------------------------------
// Core-local interruptor assertion macros
// Shared concurrent-check shorthands, sampled on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef CORE_LOCAL_INTERRUPTOR_DEFINES_SVH
`define CORE_LOCAL_INTERRUPTOR_DEFINES_SVH

// Same-cycle implication check
`define CLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define CLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clint_pkg.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor package
// Shared types, address map and operation codes.
// ----------------------------------------------------------------------------
package clint_pkg;

  // Default data-path width of the hart bus
  localparam int unsigned XLEN_DEF = 64;

  // Register file geometry: three 64-bit registers, flat little-endian store
  localparam int unsigned REG_BYTES   = 8;
  localparam int unsigned STORE_BYTES = 24;
  localparam int unsigned STORE_BITS  = STORE_BYTES * 8;

  // Address map
  localparam logic [15:0] SOFT_BASE = 16'h0000;
  localparam logic [15:0] CMP_BASE  = 16'h4000;
  localparam logic [15:0] TIME_BASE = 16'hBFF8;
  localparam logic [15:0] REG_SPAN  = 16'd8;

  // First store byte of each register
  localparam logic [4:0] START_SOFT = 5'd0;
  localparam logic [4:0] START_CMP  = 5'd8;
  localparam logic [4:0] START_TIME = 5'd16;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  // Command handed from the input stage to the register block
  typedef struct packed {
    logic       go;
    logic [1:0] op;
    logic       hit;
    logic [4:0] start;
  } clint_cmd_t;

  // Result of one step
  typedef struct packed {
    logic [63:0] read_data;
    logic        status;
    logic        timer_irq;
    logic        soft_irq;
  } clint_res_t;

endpackage

@@ sv/clint_in_if.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor request channel
// Valid/ready channel carrying one register access or timer tick.
// ----------------------------------------------------------------------------
interface clint_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [63:0] write_data;
  logic [3:0]  byte_count;

  modport source (output valid, operation, address, write_data, byte_count,
                  input ready);
  modport sink   (input valid, operation, address, write_data, byte_count,
                  output ready);
endinterface

@@ sv/clint_out_if.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor response channel
// Valid/ready channel carrying read data, status and interrupt lines.
// ----------------------------------------------------------------------------
interface clint_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        status;
  logic        timer_irq;
  logic        soft_irq;

  modport source (output valid, read_data, status, timer_irq, soft_irq,
                  input ready);
  modport sink   (input valid, read_data, status, timer_irq, soft_irq,
                  output ready);
endinterface

@@ sv/clint_decode.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor address decoder
// Maps a window offset to a start byte in the flat register store.
// ----------------------------------------------------------------------------
module clint_decode import clint_pkg::*; (
  input  logic [15:0] address,
  output logic        hit,
  output logic [4:0]  start
);

  logic [4:0] lane;

  assign lane = {2'b00, address[2:0]};

  // Range match against the three register windows
  always_comb begin
    hit   = 1'b1;
    start = START_SOFT;
    if (address < SOFT_BASE + REG_SPAN) begin
      start = START_SOFT | lane;
    end else if (address >= CMP_BASE && address < CMP_BASE + REG_SPAN) begin
      start = START_CMP | lane;
    end else if (address >= TIME_BASE && address < TIME_BASE + REG_SPAN) begin
      start = START_TIME | lane;
    end else begin
      hit = 1'b0;
    end
  end

endmodule

@@ sv/clint_regs.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor register store
// Software word, time compare and time counter with byte-lane access.
// ----------------------------------------------------------------------------
module clint_regs import clint_pkg::*; #(
  parameter int unsigned XLEN = XLEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  clint_cmd_t  cmd,
  input  logic [63:0] write_data,
  input  logic [3:0]  byte_count,
  output clint_res_t  res
);

  localparam int unsigned LANES = XLEN / 8;

  logic [STORE_BITS-1:0] store_r, store_nxt;
  logic                  phase_r, phase_nxt;
  logic [3:0]            eff_cnt;
  logic [4:0]            off;
  logic [255:0]          rd_flat;
  logic [255:0]          rd_shift;
  logic [63:0]           time_nxt;
  logic [63:0]           cmp_nxt;

  // Write length saturates at the bus width
  assign eff_cnt = (byte_count > 4'(LANES)) ? 4'(LANES) : byte_count;

  // Read window: bytes past the store come in as zero
  assign rd_flat  = {64'd0, store_r};
  assign rd_shift = rd_flat >> {cmd.start, 3'b000};

  // Next state of store and tick phase
  always_comb begin
    store_nxt = store_r;
    phase_nxt = phase_r;
    off       = 5'd0;
    if (cmd.op == OP_WRITE && cmd.hit) begin
      for (int j = 0; j < int'(STORE_BYTES); j++) begin
        off = 5'(j) - cmd.start;
        if (5'(j) >= cmd.start && off < {1'b0, eff_cnt}) begin
          store_nxt[j*8 +: 8] = write_data[{off[2:0], 3'b000} +: 8];
        end
      end
    end else if (cmd.op == OP_TICK) begin
      if (!phase_r) begin
        store_nxt[START_TIME*8 +: 64] = store_r[START_TIME*8 +: 64] + 64'd1;
      end
      phase_nxt = ~phase_r;
    end
  end

  // Result fields, interrupt lines taken after the update
  assign time_nxt = store_nxt[START_TIME*8 +: 64];
  assign cmp_nxt  = store_nxt[START_CMP*8 +: 64];

  always_comb begin
    res.read_data = 64'd0;
    res.status    = STATUS_OK;
    case (cmd.op)
      OP_READ: begin
        if (cmd.hit) begin
          res.read_data = 64'(rd_shift[XLEN-1:0]);
        end else begin
          res.status = STATUS_ERR;
        end
      end
      OP_WRITE: begin
        if (!cmd.hit) begin
          res.status = STATUS_ERR;
        end
      end
      default: begin
        res.status = STATUS_OK;
      end
    endcase
    res.timer_irq = (time_nxt >= cmp_nxt);
    res.soft_irq  = store_nxt[0];
  end

  // State update on each executed step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      phase_r <= 1'b0;
    end else if (cmd.go) begin
      store_r <= store_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

@@ sv/core_local_interruptor.sv @@
// ----------------------------------------------------------------------------
// Core-local interruptor
// Software interrupt, time compare and time counter behind a byte window.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transfer: a read, a write of up to 8 bytes,
//   or a timer tick. out_ch returns exactly one response per request, in
//   order, with read data, access status and both interrupt lines as they
//   stand after the request took effect.
//   A transferred request waits in the input register until the response
//   register is free or draining; it then executes into the response register.
//   Throughput: one request per cycle while out_ch.ready stays high, set by
//   the single execute stage that updates the register store while the next
//   request waits in the input register.
//   Reset (rst_n low, synchronous) clears all three registers, the tick
//   phase and both pipeline stages.
//   When out_ch.ready is low, the response register holds; one more request
//   may be taken into the input register, then in_ch.ready drops until the
//   response is transferred.
// ----------------------------------------------------------------------------
`include "core_local_interruptor_defines.svh"

module core_local_interruptor import clint_pkg::*; #(
  parameter int unsigned XLEN = XLEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  clint_in_if.sink    in_ch,
  clint_out_if.source out_ch
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  op_r;
  logic [15:0] addr_r;
  logic [63:0] wdata_r;
  logic [3:0]  cnt_r;
  logic        out_valid_r, out_valid_nxt;
  clint_res_t  res_r;
  clint_res_t  res;
  clint_cmd_t  cmd;
  logic        adv;
  logic        in_fire;
  logic        dec_hit;
  logic [4:0]  dec_start;

  // Handshake: execute when the response register is free or draining
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = cmd.go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_ch.operation;
      addr_r  <= in_ch.address;
      wdata_r <= in_ch.write_data;
      cnt_r   <= in_ch.byte_count;
    end
  end

  // Decode and execute
  clint_decode u_decode (
    .address (addr_r),
    .hit     (dec_hit),
    .start   (dec_start)
  );

  assign cmd.go    = s1_valid_r && adv;
  assign cmd.op    = op_r;
  assign cmd.hit   = dec_hit;
  assign cmd.start = dec_start;

  clint_regs #(
    .XLEN (XLEN)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .write_data (wdata_r),
    .byte_count (cnt_r),
    .res        (res)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = res_r.read_data;
  assign out_ch.status    = res_r.status;
  assign out_ch.timer_irq = res_r.timer_irq;
  assign out_ch.soft_irq  = res_r.soft_irq;

  // Checks
  `CLI_ASSERT_NEXT(a_fire_loads, in_fire, s1_valid_r, "accepted request lost")
  `CLI_ASSERT_NEXT(a_exec_resp, cmd.go, out_valid_r, "executed request gave no response")
  `CLI_ASSERT_NOW(a_err_zero, out_valid_r && res_r.status == STATUS_ERR,
    res_r.read_data == 64'd0, "error response carries data")

endmodule

@@ sim/core_local_interruptor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core-local interruptor testbench
// Drives reads, writes, timer ticks and unmapped accesses through the request
// channel, predicts every response from a local copy of the register store,
// and checks each response field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module core_local_interruptor_tb;
  import clint_pkg::*;

  localparam int unsigned BUS_BYTES    = XLEN_DEF / 8;
  localparam logic [1:0]  OP_NONE      = 2'd3;   // unused operation code
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LONG_HOLD    = 300;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  clint_in_if  in_ch ();
  clint_out_if out_ch ();

  core_local_interruptor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted register store and tick phase
  logic [7:0] store_bytes [STORE_BYTES];
  logic       tick_phase;

  clint_res_t pending_results [$];

  bit steady        = 1'b0;   // no random idling on either side while set
  int stall_request = 0;      // response hold-off, picked up by the receiver
  int error_count     = 0;
  int results_checked = 0;
  int cycle_count     = 0;
  int input_stalls    = 0;
  int n_read = 0, n_write = 0, n_tick = 0, n_unmapped = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Store byte selected by an offset, -1 when no register is hit
  function automatic int start_of(input logic [15:0] addr);
    if (addr < SOFT_BASE + REG_SPAN)
      return int'(START_SOFT) + int'(addr[2:0]);
    if (addr >= CMP_BASE && addr < CMP_BASE + REG_SPAN)
      return int'(START_CMP) + int'(addr[2:0]);
    if (addr >= TIME_BASE && addr < TIME_BASE + REG_SPAN)
      return int'(START_TIME) + int'(addr[2:0]);
    return -1;
  endfunction

  function automatic logic [63:0] reg_value(input int base);
    logic [63:0] v;
    v = '0;
    for (int k = int'(REG_BYTES) - 1; k >= 0; k--)
      v = (v << 8) | 64'(store_bytes[base + k]);
    return v;
  endfunction

  // Applies one request to the store and returns the response it yields
  function automatic clint_res_t predict_clint(input logic [1:0] op,
                                               input logic [15:0] addr,
                                               input logic [63:0] wdata,
                                               input logic [3:0] cnt);
    clint_res_t r;
    int s;
    int n;
    logic [63:0] t;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_READ || op == OP_WRITE) begin
      s = start_of(addr);
      if (s < 0) begin
        r.status = STATUS_ERR;
        n_unmapped++;
      end else if (op == OP_READ) begin
        // bytes past the store read as zero
        for (int k = int'(BUS_BYTES) - 1; k >= 0; k--)
          r.read_data = (r.read_data << 8) |
                        64'((s + k < int'(STORE_BYTES)) ? store_bytes[s + k] : 8'h00);
        n_read++;
      end else begin
        // count saturates at the bus width; bytes past the store are dropped
        n = int'(cnt);
        if (n > int'(BUS_BYTES)) n = int'(BUS_BYTES);
        for (int k = 0; k < n; k++)
          if (s + k < int'(STORE_BYTES)) store_bytes[s + k] = wdata[8*k +: 8];
        n_write++;
      end
    end else if (op == OP_TICK) begin
      if (!tick_phase) begin
        t = reg_value(START_TIME) + 64'd1;
        for (int k = 0; k < int'(REG_BYTES); k++)
          store_bytes[int'(START_TIME) + k] = t[8*k +: 8];
      end
      tick_phase = ~tick_phase;
      n_tick++;
    end
    r.timer_irq = (reg_value(START_TIME) >= reg_value(START_CMP));
    r.soft_irq  = store_bytes[START_SOFT][0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // One request transfer; returns at the edge that accepted it, valid still high
  task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                           input logic [63:0] wdata, input logic [3:0] cnt);
    if (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.address    <= addr;
    in_ch.write_data <= wdata;
    in_ch.byte_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_clint(op, addr, wdata, cnt));
  endtask

  // Mostly mapped accesses and ticks, with values near the live counter
  task automatic random_item();
    int pick;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [63:0] wdata;
    logic [3:0]  cnt;
    pick = $urandom_range(99);
    if (pick < 30)      op = OP_READ;
    else if (pick < 62) op = OP_WRITE;
    else if (pick < 96) op = OP_TICK;
    else                op = OP_NONE;

    pick = $urandom_range(99);
    if (pick < 25)      addr = SOFT_BASE + 16'($urandom_range(0, 7));
    else if (pick < 55) addr = CMP_BASE + 16'($urandom_range(0, 7));
    else if (pick < 85) addr = TIME_BASE + 16'($urandom_range(0, 7));
    else                addr = 16'($urandom());

    case ($urandom_range(3))
      0:       wdata = {$urandom(), $urandom()};
      1:       wdata = 64'($urandom_range(0, 3));
      2:       wdata = reg_value(START_TIME) + 64'($urandom_range(0, 6));
      default: wdata = ~64'($urandom_range(0, 3));
    endcase

    pick = $urandom_range(99);
    if (pick < 10)      cnt = 4'($urandom_range(0, 15));
    else if (pick < 60) cnt = 4'd8;
    else                cnt = 4'($urandom_range(1, 8));

    send_item(op, addr, wdata, cnt);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare each response transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    clint_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, expected none, actual read_data %h status %b",
                 $time, out_ch.read_data, out_ch.status);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        check_field("read_data", want.read_data, out_ch.read_data);
        check_field("status", 64'(want.status), 64'(out_ch.status));
        check_field("timer_irq", 64'(want.timer_irq), 64'(out_ch.timer_irq));
        check_field("soft_irq", 64'(want.soft_irq), 64'(out_ch.soft_irq));
      end
    end
    if (rst_n && in_ch.valid && !in_ch.ready) input_stalls++;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("core_local_interruptor_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register extremes, crossings, past-store bytes, unmapped offsets, wrap
  task automatic test_directed();
    send_item(OP_READ,  16'h0000, 64'h0, 4'd8);
    send_item(OP_READ,  TIME_BASE, 64'h0, 4'd8);
    send_item(OP_WRITE, SOFT_BASE, '1, 4'd8);               // soft irq on
    send_item(OP_READ,  16'h0007, 64'h0, 4'd8);             // runs into compare
    send_item(OP_WRITE, CMP_BASE, '1, 4'd8);                // compare at max
    send_item(OP_READ,  16'h4007, 64'h0, 4'd8);             // runs into counter
    send_item(OP_WRITE, TIME_BASE, '1, 4'd8);               // counter at max
    send_item(OP_TICK,  16'h0000, 64'h0, 4'd0);             // counter wraps
    send_item(OP_TICK,  16'hFFFF, '1, 4'd15);               // odd tick, no step
    send_item(OP_TICK,  16'h0000, 64'h0, 4'd0);
    send_item(OP_WRITE, 16'hBFFC, 64'h1122334455667788, 4'd8); // tail dropped
    send_item(OP_READ,  16'hBFFF, 64'h0, 4'd8);             // reads past store
    send_item(OP_WRITE, 16'h0003, '1, 4'd0);                // zero-byte write
    send_item(OP_WRITE, SOFT_BASE, 64'h0, 4'd15);           // count saturates
    send_item(OP_WRITE, 16'h4001, 64'hA5, 4'd1);
    send_item(OP_READ,  CMP_BASE, 64'h0, 4'd8);
    send_item(OP_READ,  16'h0008, 64'h0, 4'd8);             // unmapped
    send_item(OP_WRITE, 16'h3FFF, '1, 4'd8);
    send_item(OP_READ,  16'h4008, 64'h0, 4'd8);
    send_item(OP_WRITE, 16'hBFF7, '1, 4'd8);
    send_item(OP_READ,  16'hFFFF, 64'h0, 4'd8);
    send_item(OP_NONE,  16'h0000, '1, 4'd8);                // unused operation
    send_item(OP_READ,  TIME_BASE, 64'h0, 4'd8);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) random_item();
  endtask

  // Responses held off while requests keep coming: input must back up
  task automatic test_long_stall();
    steady = 1'b1;
    stall_request = LONG_HOLD;
    repeat (60) random_item();
    steady = 1'b0;
  endtask

  // Sender goes quiet until every response is back, then resumes
  task automatic test_drain_pause();
    repeat (30) random_item();
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (30) random_item();
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.operation  <= OP_READ;
    in_ch.address    <= '0;
    in_ch.write_data <= '0;
    in_ch.byte_count <= '0;
    rst_n            <= 1'b0;
    foreach (store_bytes[i]) store_bytes[i] = 8'h00;
    tick_phase = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(500);
    test_long_stall();
    steady = 1'b1;                 // long stretch with no idling at all
    test_random_traffic(300);
    steady = 1'b0;
    test_drain_pause();
    test_random_traffic(800);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d ticks, %0d unmapped accesses; %0d checked.",
             n_read, n_write, n_tick, n_unmapped, results_checked);
    $display("Request channel stalled %0d cycles under response back-pressure.",
             input_stalls);
    if (error_count == 0) begin
      $display("core_local_interruptor_tb OK");
    end else begin
      $display("core_local_interruptor_tb NOT OK");
    end
    $finish;
  end

endmodule
